// ----- hdl/handle_table_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// handle table allocator assertion macros
// concurrent assertion forms used by the rtl file hta_ctrl.sv
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_MACROS_SVH
`define HANDLE_TABLE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define HTA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HTA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hta_pkg.sv -----
// ----------------------------------------------------------------------------
// hta_pkg
// types and codes shared by the handle table allocator modules
// ----------------------------------------------------------------------------
`default_nettype none

package hta_pkg;

  localparam int HANDLE_W = 8;
  localparam int VALUE_W  = 64;

  typedef enum logic [1:0] {
    ACT_WRAP   = 2'd0,
    ACT_UNWRAP = 2'd1,
    ACT_FREE   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MATCH,
    S_FREE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [VALUE_W-1:0]  value;
    status_t             status;
  } res_t;

endpackage

`default_nettype wire

// ----- hdl/handle_table_allocator.sv -----
// ----------------------------------------------------------------------------
// handle_table_allocator
// maps small handles to 64-bit host values, next-fit slot allocation
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries action, host_value, handle_in;
//   output channel (out_valid/out_ready) returns handle_out, value_out and
//   status, exactly one result per request, in request order.
// throughput: one request at a time; the slot memory read port paces the
//   wrap search and free scan at one slot per cycle.
// reset: a sweep writes every slot to zero; in_ready stays
//   low during the sweep, and next_slot restarts at 1.
// stall: the output register holds a finished result while out_ready is low;
//   one more request is accepted and worked on, then held until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module handle_table_allocator
  import hta_pkg::*;
#(
  parameter int SLOTS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          action,
  input  wire logic [VALUE_W-1:0]  host_value,
  input  wire logic [HANDLE_W-1:0] handle_in,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [HANDLE_W-1:0] handle_out,
  output logic      [VALUE_W-1:0]  value_out,
  output logic      [1:0]          status
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic               res_valid;
  logic               res_ready;
  res_t               res;
  res_t               out_q;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [VALUE_W-1:0] wr_data;

  // request sequencer
  hta_ctrl #(
    .SLOTS(SLOTS),
    .AW   (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .host_value(host_value),
    .handle_in (handle_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // slot value memory
  hta_mem #(
    .DEPTH(SLOTS),
    .AW   (AW),
    .DW   (VALUE_W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // output register
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign handle_out = out_q.handle;
  assign value_out  = out_q.value;
  assign status     = out_q.status;

endmodule

`default_nettype wire

// ----- hdl/hta_mem.sv -----
// ----------------------------------------------------------------------------
// hta_mem
// slot value store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module hta_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/hta_ctrl.sv -----
// ----------------------------------------------------------------------------
// hta_ctrl
// request sequencer: clearing sweep, match search, next-fit free scan
// ----------------------------------------------------------------------------
`default_nettype none

`include "handle_table_allocator_macros.svh"

module hta_ctrl
  import hta_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int AW    = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          action,
  input  wire logic [VALUE_W-1:0]  host_value,
  input  wire logic [HANDLE_W-1:0] handle_in,
  output logic                     res_valid,
  input  wire logic                res_ready,
  output res_t                     res,
  output logic                     rd_en,
  output logic      [AW-1:0]       rd_addr,
  input  wire logic [VALUE_W-1:0]  rd_data,
  output logic                     wr_en,
  output logic      [AW-1:0]       wr_addr,
  output logic      [VALUE_W-1:0]  wr_data
);

  localparam logic [AW-1:0] LAST  = AW'(SLOTS - 1);
  localparam logic [AW-1:0] FIRST = AW'(1);

  state_t               state, state_next;
  logic [VALUE_W-1:0]   value_q, value_next;
  logic [AW-1:0]        sweep_ptr, sweep_next;
  logic [AW-1:0]        issue_idx, issue_next;
  logic [AW-1:0]        issue_cnt, cnt_next;
  logic                 chk_vld, chk_vld_next;
  logic [AW-1:0]        chk_idx, chk_idx_next;
  logic [AW-1:0]        next_slot, next_slot_next;
  logic                 clr_report, clr_report_next;
  res_t                 res_next;
  logic                 h_ok;
  logic [AW-1:0]        h_idx;
  logic                 hit;

  // next slot with wrap from the top back to slot one
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] i);
    slot_inc = (i == LAST) ? FIRST : i + FIRST;
  endfunction

  // handle decode
  assign h_ok  = (handle_in != '0) && (32'(handle_in) < 32'(SLOTS));
  assign h_idx = AW'({{AW{1'b0}}, handle_in});

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_RESULT);

  // scan compare on the data read last cycle
  assign hit = chk_vld &&
               ((state == S_MATCH) ? (rd_data == value_q) : (rd_data == '0));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_ptr  <= '0;
      clr_report <= 1'b0;
      chk_vld    <= 1'b0;
      next_slot  <= FIRST;
    end else begin
      state      <= state_next;
      sweep_ptr  <= sweep_next;
      clr_report <= clr_report_next;
      chk_vld    <= chk_vld_next;
      next_slot  <= next_slot_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    value_q   <= value_next;
    issue_idx <= issue_next;
    issue_cnt <= cnt_next;
    chk_idx   <= chk_idx_next;
    res       <= res_next;
  end

  // next state and memory control
  always_comb begin
    state_next      = state;
    value_next      = value_q;
    sweep_next      = sweep_ptr;
    issue_next      = issue_idx;
    cnt_next        = issue_cnt;
    chk_vld_next    = 1'b0;
    chk_idx_next    = issue_idx;
    next_slot_next  = next_slot;
    clr_report_next = clr_report;
    res_next        = res;
    rd_en           = 1'b0;
    rd_addr         = issue_idx;
    wr_en           = 1'b0;
    wr_addr         = chk_idx;
    wr_data         = value_q;

    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = sweep_ptr;
        wr_data = '0;
        if (sweep_ptr == LAST) begin
          next_slot_next = FIRST;
          res_next       = '{handle: '0, value: '0, status: ST_OK};
          state_next     = clr_report ? S_RESULT : S_IDLE;
        end else begin
          sweep_next = sweep_ptr + FIRST;
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          value_next = host_value;
          case (action)
            ACT_WRAP: begin
              if (host_value == '0) begin
                res_next   = '{handle: '0, value: '0, status: ST_INVALID};
                state_next = S_RESULT;
              end else begin
                issue_next = FIRST;
                cnt_next   = '0;
                state_next = S_MATCH;
              end
            end
            ACT_UNWRAP: begin
              if (!h_ok) begin
                res_next   = '{handle: '0, value: '0, status: ST_INVALID};
                state_next = S_RESULT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = h_idx;
                state_next = S_READ;
              end
            end
            ACT_FREE: begin
              if (!h_ok) begin
                res_next = '{handle: '0, value: '0, status: ST_INVALID};
              end else begin
                wr_en    = 1'b1;
                wr_addr  = h_idx;
                wr_data  = '0;
                res_next = '{handle: '0, value: '0, status: ST_OK};
              end
              state_next = S_RESULT;
            end
            default: begin
              sweep_next      = '0;
              clr_report_next = 1'b1;
              state_next      = S_CLEAR;
            end
          endcase
        end
      end

      S_READ: begin
        res_next   = '{handle: '0, value: rd_data, status: ST_OK};
        state_next = S_RESULT;
      end

      S_MATCH, S_FREE: begin
        if (hit) begin
          // match found, or empty slot claimed
          if (state == S_FREE) begin
            wr_en          = 1'b1;
            wr_addr        = chk_idx;
            wr_data        = value_q;
            next_slot_next = slot_inc(chk_idx);
          end
          res_next   = '{handle: HANDLE_W'({{HANDLE_W{1'b0}}, chk_idx}), value: '0,
                         status: ST_OK};
          state_next = S_RESULT;
        end else if (issue_cnt != LAST) begin
          // keep one read in flight per cycle
          rd_en        = 1'b1;
          chk_vld_next = 1'b1;
          chk_idx_next = issue_idx;
          issue_next   = slot_inc(issue_idx);
          cnt_next     = issue_cnt + FIRST;
        end else if (!chk_vld) begin
          if (state == S_MATCH) begin
            issue_next = next_slot;
            cnt_next   = '0;
            state_next = S_FREE;
          end else begin
            res_next   = '{handle: '0, value: '0, status: ST_FULL};
            state_next = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // checks
  `HTA_ASSERT_IMP(a_rw_apart, clk, rst, rd_en && wr_en, rd_addr != wr_addr,
                  "read and write hit the same slot")
  `HTA_ASSERT_NXT(a_clear_sweep, clk, rst, in_valid && in_ready && action == ACT_CLEAR,
                  state == S_CLEAR && sweep_ptr == '0, "clear did not start a sweep")
  `HTA_ASSERT_IMP(a_full_null, clk, rst, res_valid && res.status == ST_FULL,
                  res.handle == '0, "full status with a nonzero handle")
  `HTA_ASSERT_IMP(a_next_slot, clk, rst, state == S_IDLE,
                  next_slot != '0 && 32'(next_slot) < 32'(SLOTS),
                  "next slot out of range")

endmodule

`default_nettype wire

// ----- dv/tb_handle_table_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_handle_table_allocator
// self-checking bench for the handle table allocator: a shadow table in a
// small scoreboard class predicts every result, with directed corner requests,
// random request mixes, table fill episodes and random stalls on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb_handle_table_allocator;
  import hta_pkg::*;

  localparam int SLOTS          = 256;
  localparam int TOTAL_REQUESTS = 1050;
  localparam int LONG_HOLD      = 3000;

  // shadow of the slot table and the queue of results still owed by the block
  class handle_table_tracker;
    logic [VALUE_W-1:0] slot_value [SLOTS];
    int unsigned        next_slot_ptr;
    res_t               expected_results [$];
    int unsigned        failures;
    int unsigned        results_seen;
    int unsigned        n_alloc, n_match, n_full, n_invalid, n_unwrap, n_free, n_clear;

    function new();
      empty_table();
    endfunction

    function void empty_table();
      foreach (slot_value[i]) slot_value[i] = '0;
      next_slot_ptr = 1;
    endfunction

    function int unsigned free_slots();
      int unsigned cnt;
      cnt = 0;
      for (int i = 1; i < SLOTS; i++)
        if (slot_value[i] == '0) cnt++;
      return cnt;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function logic [VALUE_W-1:0] value_at(logic [HANDLE_W-1:0] hnd);
      return slot_value[hnd];
    endfunction

    // an occupied handle if there is one, else some valid handle
    function logic [HANDLE_W-1:0] live_handle();
      int unsigned start;
      int unsigned h;
      start = $urandom_range(1, SLOTS - 1);
      for (int n = 0; n < SLOTS - 1; n++) begin
        h = 1 + (start - 1 + n) % (SLOTS - 1);
        if (slot_value[h] != '0) return HANDLE_W'(h);
      end
      return HANDLE_W'(start);
    endfunction

    // update the shadow table for an accepted request and queue its result
    function void note_request(action_t act, logic [VALUE_W-1:0] val,
                               logic [HANDLE_W-1:0] hnd);
      res_t        res;
      int unsigned idx;
      bit          done;
      res  = '{handle: '0, value: '0, status: ST_OK};
      done = 1'b0;
      case (act)
        ACT_WRAP: begin
          if (val == '0) begin
            res.status = ST_INVALID;
            n_invalid++;
          end else begin
            // lowest handle holding the same value wins
            for (int i = 1; i < SLOTS && !done; i++) begin
              if (slot_value[i] == val) begin
                res.handle = HANDLE_W'(i);
                done       = 1'b1;
                n_match++;
              end
            end
            // next-fit scan for an empty slot, skipping the null slot
            idx = next_slot_ptr;
            for (int n = 1; n < SLOTS && !done; n++) begin
              if (slot_value[idx] == '0) begin
                slot_value[idx] = val;
                res.handle      = HANDLE_W'(idx);
                next_slot_ptr   = (idx + 1 < SLOTS) ? idx + 1 : 1;
                done            = 1'b1;
                n_alloc++;
              end else begin
                idx = (idx + 1 < SLOTS) ? idx + 1 : 1;
              end
            end
            if (!done) begin
              res.status = ST_FULL;
              n_full++;
            end
          end
        end
        ACT_UNWRAP, ACT_FREE: begin
          if (hnd == 0 || hnd >= SLOTS) begin
            res.status = ST_INVALID;
            n_invalid++;
          end else if (act == ACT_UNWRAP) begin
            res.value = slot_value[hnd];
            n_unwrap++;
          end else begin
            slot_value[hnd] = '0;
            n_free++;
          end
        end
        default: begin
          empty_table();
          n_clear++;
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%0t ERROR %s", $time, msg);
    endfunction

    // compare one delivered result against the oldest prediction
    function void check_result(logic [HANDLE_W-1:0] hnd, logic [VALUE_W-1:0] val,
                               logic [1:0] st);
      res_t exp;
      results_seen++;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result handle %0d value %h status %0d", hnd, val, st));
        return;
      end
      exp = expected_results.pop_front();
      if (hnd !== exp.handle || val !== exp.value || st !== exp.status)
        report($sformatf({"result %0d: expected handle %0d value %h status %0d,",
                          " got handle %0d value %h status %0d"}, results_seen,
                         exp.handle, exp.value, exp.status, hnd, val, st));
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  action_t             action     = ACT_UNWRAP;
  logic [VALUE_W-1:0]  host_value = '0;
  logic [HANDLE_W-1:0] handle_in  = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic [HANDLE_W-1:0] handle_out;
  logic [VALUE_W-1:0]  value_out;
  logic [1:0]          status;

  handle_table_tracker tracker = new();

  bit          idle_on   = 1'b1;
  bit          gap_mode  = 1'b1;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned sent      = 0;

  handle_table_allocator #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .host_value (host_value),
    .handle_in  (handle_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .handle_out (handle_out),
    .value_out  (value_out),
    .status     (status)
  );

  always #5 clk = ~clk;

  // host values with varied bit patterns
  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0:       return 64'(1) << $urandom_range(0, 63);
      1:       return ~(64'(1) << $urandom_range(0, 63));
      2:       return 64'($urandom_range(1, 255));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // offer one request and hold it until accepted
  task automatic send_request(action_t act, logic [VALUE_W-1:0] val,
                              logic [HANDLE_W-1:0] hnd);
    if (idle_on && gap_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    host_value <= val;
    handle_in  <= hnd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(act, val, hnd);
    sent++;
  endtask

  // unused fields carry random noise
  task automatic do_wrap(logic [VALUE_W-1:0] val);
    send_request(ACT_WRAP, val, HANDLE_W'($urandom));
  endtask

  task automatic do_unwrap(logic [HANDLE_W-1:0] hnd);
    send_request(ACT_UNWRAP, {$urandom, $urandom}, hnd);
  endtask

  task automatic do_free(logic [HANDLE_W-1:0] hnd);
    send_request(ACT_FREE, {$urandom, $urandom}, hnd);
  endtask

  task automatic do_clear();
    send_request(ACT_CLEAR, {$urandom, $urandom}, HANDLE_W'($urandom));
  endtask

  // result checking on every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_result(handle_out, value_out, status);
  end

  // result side: random stall bursts, quiet stretches and one long hold-off
  initial begin : result_sink
    int unsigned mode_left;
    bit          stall_mode;
    mode_left  = 100;
    stall_mode = 1'b1;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 1);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (idle_on && stall_mode && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // request stimulus
  initial begin : stimulus
    int unsigned r;
    int unsigned n;
    int unsigned fills;
    fills = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed corners: invalid and empty handles, null value, match, next-fit
    do_unwrap(8'd0);
    do_free(8'd0);
    do_unwrap(8'd255);
    do_free(8'd255);
    do_wrap(64'd0);
    do_wrap('1);
    do_wrap('1);
    do_wrap(64'd1);
    do_wrap(64'h8000_0000_0000_0000);
    do_wrap(64'h5555_5555_5555_5555);
    do_wrap(64'hAAAA_AAAA_AAAA_AAAA);
    do_unwrap(8'd1);
    do_unwrap(8'd5);
    do_unwrap(8'hAA);
    do_free(8'd1);
    do_unwrap(8'd1);
    do_wrap(64'd1);
    do_wrap(64'hDEAD_BEEF_0000_0001);
    do_free(8'h55);
    do_clear();
    do_unwrap(8'd2);
    do_wrap(64'h1234_5678_9ABC_DEF0);
    do_unwrap(8'd1);

    // random episodes
    while (sent < TOTAL_REQUESTS) begin
      idle_on  = (sent < TOTAL_REQUESTS - 80);
      gap_mode = ($urandom_range(0, 2) != 0);
      if (!hold_done && sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (fills < 2 && (r < 3 || (fills == 0 && sent > 170) || (fills == 1 && sent > 620)))
      begin
        // fill the table, hit it while full, then punch holes and refill
        fills++;
        while (tracker.free_slots() != 0) do_wrap({$urandom, $urandom});
        repeat ($urandom_range(2, 4)) do_wrap(random_value());
        do_wrap(tracker.value_at(tracker.live_handle()));
        n = $urandom_range(1, 4);
        repeat (n) do_free(tracker.live_handle());
        repeat (n + 1) do_wrap({$urandom, $urandom});
      end else if (r < 10) begin
        do_clear();
      end else if (r < 45) begin
        case ($urandom_range(0, 9))
          0:       do_wrap('0);
          1, 2, 3: do_wrap(tracker.value_at(tracker.live_handle()));
          default: do_wrap(random_value());
        endcase
      end else if (r < 70) begin
        case ($urandom_range(0, 6))
          0:       do_unwrap(8'd0);
          1, 2:    do_unwrap(HANDLE_W'($urandom));
          default: do_unwrap(tracker.live_handle());
        endcase
      end else if (r < 90) begin
        case ($urandom_range(0, 6))
          0:       do_free(8'd0);
          1, 2:    do_free(HANDLE_W'($urandom));
          default: do_free(tracker.live_handle());
        endcase
      end else begin
        send_request(action_t'($urandom_range(0, 3)), {$urandom, $urandom},
                     HANDLE_W'($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray results
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * SLOTS + 16) @(posedge clk);

    $display("requests %0d: %0d allocations, %0d matches, %0d table full, %0d invalid",
             sent, tracker.n_alloc, tracker.n_match, tracker.n_full, tracker.n_invalid);
    $display("unwraps %0d, frees %0d, clears %0d, table fills %0d; results %0d, errors %0d",
             tracker.n_unwrap, tracker.n_free, tracker.n_clear, fills,
             tracker.results_seen, tracker.failures);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- handle_table_allocator.f -----
+incdir+hdl
hdl/hta_pkg.sv
hdl/hta_mem.sv
hdl/hta_ctrl.sv
hdl/handle_table_allocator.sv
dv/tb_handle_table_allocator.sv
